// ===== sv/hapf_pkg.sv =====
package hapf_pkg;

	// packet geometry
	localparam int PACKET_BYTES = 64;
	localparam int HEADER_BYTES = 5;
	localparam int PREFIX_BYTES = 2;
	localparam int FILL_W       = 7;

	// register reset values
	localparam logic [15:0] CHANNEL_ID_RESET  = 16'h0101;
	localparam logic [7:0]  COMMAND_TAG_RESET = 8'h05;

	// register map, selected by paddr[2]
	localparam int          ADDR_W          = 3;
	localparam logic [0:0]  REG_CHANNEL_ID  = 1'b0;
	localparam logic [0:0]  REG_COMMAND_TAG = 1'b1;

	// byte positions inside one request's output burst
	localparam int          POS_W      = 3;
	localparam logic [2:0]  POS_CH_HI  = 3'd0;
	localparam logic [2:0]  POS_CH_LO  = 3'd1;
	localparam logic [2:0]  POS_TAG    = 3'd2;
	localparam logic [2:0]  POS_SEQ_HI = 3'd3;
	localparam logic [2:0]  POS_SEQ_LO = 3'd4;
	localparam logic [2:0]  POS_LEN_HI = 3'd5;
	localparam logic [2:0]  POS_LEN_LO = 3'd6;
	localparam logic [2:0]  POS_DATA   = 3'd7;

	// queue depth between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_CNT_W = 2;

	// how a request is framed
	typedef enum logic [1:0] {
		OP_DATA  = 2'd0,
		OP_CONT  = 2'd1,
		OP_FIRST = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data;
		logic [15:0] len;
		logic [15:0] seq;
		logic        eop;
		logic        eom;
	} op_t;

	typedef struct packed {
		logic [15:0] channel_id;
		logic [7:0]  command_tag;
	} cfg_t;

endpackage

// ===== sv/hapf_front.sv =====
module hapf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic [15:0]         message_length,
	input  logic                last_of_message,
	output hapf_pkg::op_t       op
);

	logic                        in_msg_q;
	logic [hapf_pkg::FILL_W-1:0] fill_q;
	logic [15:0]                 seq_q;

	hapf_pkg::op_kind_t          kind;
	logic [hapf_pkg::FILL_W-1:0] fill_base;
	logic [hapf_pkg::FILL_W-1:0] fill_next;
	logic [15:0]                 seq_use;
	logic                        pkt_full;

	// classify the request against the framing state
	always_comb begin
		priority if (!in_msg_q) begin
			kind      = hapf_pkg::OP_FIRST;
			seq_use   = 16'd0;
			fill_base = hapf_pkg::FILL_W'(hapf_pkg::HEADER_BYTES + hapf_pkg::PREFIX_BYTES);
		end else if (fill_q == '0) begin
			kind      = hapf_pkg::OP_CONT;
			seq_use   = seq_q;
			fill_base = hapf_pkg::FILL_W'(hapf_pkg::HEADER_BYTES);
		end else begin
			kind      = hapf_pkg::OP_DATA;
			seq_use   = seq_q;
			fill_base = fill_q;
		end
		fill_next = fill_base + hapf_pkg::FILL_W'(1);
		pkt_full  = fill_next >= hapf_pkg::FILL_W'(hapf_pkg::PACKET_BYTES);
	end

	// request handed to the queue
	always_comb begin
		op.kind = kind;
		op.data = data_byte;
		op.len  = message_length;
		op.seq  = seq_use;
		op.eop  = last_of_message || pkt_full;
		op.eom  = last_of_message;
	end

	// framing state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			fill_q   <= '0;
			seq_q    <= '0;
		end else if (take) begin
			priority if (last_of_message) begin
				in_msg_q <= 1'b0;
				fill_q   <= '0;
				seq_q    <= '0;
			end else if (pkt_full) begin
				in_msg_q <= 1'b1;
				fill_q   <= '0;
				seq_q    <= seq_use + 16'd1;
			end else begin
				in_msg_q <= 1'b1;
				fill_q   <= fill_next;
				seq_q    <= seq_use;
			end
		end
	end

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < hapf_pkg::FILL_W'(hapf_pkg::PACKET_BYTES))
		else $error("packet fill out of range");

	a_idle_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_msg_q |-> (fill_q == '0 && seq_q == 16'd0))
		else $error("framing state not cleared between messages");

endmodule

// ===== sv/hapf_queue.sv =====
module hapf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  hapf_pkg::op_t  wr_op,
	input  logic           rd,
	output hapf_pkg::op_t  rd_op,
	output logic           q_full,
	output logic           q_empty
);

	hapf_pkg::op_t                entry_q [hapf_pkg::Q_DEPTH];
	logic                         wr_ptr_q;
	logic                         rd_ptr_q;
	logic [hapf_pkg::Q_CNT_W-1:0] count_q;

	assign q_full  = count_q == hapf_pkg::Q_CNT_W'(hapf_pkg::Q_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_op   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_op;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + hapf_pkg::Q_CNT_W'(1);
				2'b01:   count_q <= count_q - hapf_pkg::Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hapf_pkg::Q_CNT_W'(hapf_pkg::Q_DEPTH))
		else $error("queue overflow");

endmodule

// ===== sv/hapf_back.sv =====
module hapf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hapf_pkg::cfg_t cfg,
	input  hapf_pkg::op_t  head,
	input  logic           head_valid,
	output logic           head_done,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     packet_byte,
	output logic           end_of_packet,
	output logic           end_of_message
);

	logic [hapf_pkg::POS_W-1:0] idx_q;
	logic                       out_valid_q;
	logic [7:0]                 byte_q;
	logic                       eop_q;
	logic                       eom_q;

	logic                       is_data;
	logic                       advance;
	logic [7:0]                 byte_sel;

	// the data byte closes every request's burst
	always_comb begin
		unique case (head.kind)
			hapf_pkg::OP_DATA:  is_data = 1'b1;
			hapf_pkg::OP_CONT:  is_data = idx_q == hapf_pkg::POS_LEN_HI;
			hapf_pkg::OP_FIRST: is_data = idx_q == hapf_pkg::POS_DATA;
			default:            is_data = 1'b1;
		endcase
	end

	// byte select by position
	always_comb begin
		if (is_data) begin
			byte_sel = head.data;
		end else begin
			unique case (idx_q)
				hapf_pkg::POS_CH_HI:  byte_sel = cfg.channel_id[15:8];
				hapf_pkg::POS_CH_LO:  byte_sel = cfg.channel_id[7:0];
				hapf_pkg::POS_TAG:    byte_sel = cfg.command_tag;
				hapf_pkg::POS_SEQ_HI: byte_sel = head.seq[15:8];
				hapf_pkg::POS_SEQ_LO: byte_sel = head.seq[7:0];
				hapf_pkg::POS_LEN_HI: byte_sel = head.len[15:8];
				hapf_pkg::POS_LEN_LO: byte_sel = head.len[7:0];
				default:              byte_sel = head.data;
			endcase
		end
	end

	assign advance   = head_valid && (!out_valid_q || pop);
	assign head_done = advance && is_data;

	// position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= is_data ? '0 : idx_q + hapf_pkg::POS_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_sel;
			eop_q  <= is_data && head.eop;
			eom_q  <= is_data && head.eom;
		end
	end

	assign empty          = !out_valid_q;
	assign packet_byte    = byte_q;
	assign end_of_packet  = eop_q;
	assign end_of_message = eom_q;

	a_data_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head.kind == hapf_pkg::OP_DATA) |-> idx_q == '0)
		else $error("plain data request entered mid-burst");

	a_cont_burst_short: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head.kind == hapf_pkg::OP_CONT) |-> idx_q <= hapf_pkg::POS_LEN_HI)
		else $error("continuation burst ran past its data byte");

	a_eom_has_eop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eom_q) |-> eop_q)
		else $error("end of message without end of packet");

endmodule

// ===== sv/hid_apdu_packet_framer_core.sv =====
// HID APDU packet framer. APDU bytes are pushed one per request; message_length is
// sampled on the first byte of a message and last_of_message closes it. The block
// emits 64-byte HID packets as a byte stream: a 5-byte header (channel id, command
// tag, sequence number, big-endian), then on the first packet a 2-byte length
// prefix, then data; the final packet is cut short. One output byte leaves per
// cycle from the back sequencer while a request is queued and pop drains the
// output register: a plain data request yields its data byte, the first byte of
// a message the header, length prefix and data byte, a later packet's first byte
// the header and data byte. A two-entry request queue plus the output register
// let push proceed every cycle until the header bursts back up. channel_id sits at
// address 0 and command_tag at address 4; write them only while the block is idle.
module hid_apdu_packet_framer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  data_byte,
	input  logic [15:0]                 message_length,
	input  logic                        last_of_message,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  packet_byte,
	output logic                        end_of_packet,
	output logic                        end_of_message,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hapf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	hapf_pkg::cfg_t cfg_q;
	hapf_pkg::op_t  front_op;
	hapf_pkg::op_t  head_op;
	logic           take;
	logic           q_full;
	logic           q_empty;
	logic           head_done;
	logic           cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_id  <= hapf_pkg::CHANNEL_ID_RESET;
			cfg_q.command_tag <= hapf_pkg::COMMAND_TAG_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2:2])
				hapf_pkg::REG_CHANNEL_ID:  cfg_q.channel_id  <= pwdata[15:0];
				hapf_pkg::REG_COMMAND_TAG: cfg_q.command_tag <= pwdata[7:0];
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			hapf_pkg::REG_CHANNEL_ID:  prdata = {16'd0, cfg_q.channel_id};
			hapf_pkg::REG_COMMAND_TAG: prdata = {24'd0, cfg_q.command_tag};
			default:                   prdata = 32'd0;
		endcase
	end

	// input side
	assign full = q_full;
	assign take = push && !q_full;

	hapf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.data_byte       (data_byte),
		.message_length  (message_length),
		.last_of_message (last_of_message),
		.op              (front_op)
	);

	hapf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_op   (front_op),
		.rd      (head_done),
		.rd_op   (head_op),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	hapf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head           (head_op),
		.head_valid     (!q_empty),
		.head_done      (head_done),
		.pop            (pop),
		.empty          (empty),
		.packet_byte    (packet_byte),
		.end_of_packet  (end_of_packet),
		.end_of_message (end_of_message)
	);

endmodule
